[hdl/sigk_pkg.sv]
// Shared types and constants for the signature kernel PDE solver.
// No dependencies; sigk_front, sigk_queue, sigk_back and the top level import it.
package sigk_pkg;

  // Fixed point one in Q24.40.
  localparam logic [63:0] Q_ONE = 64'h0000_0100_0000_0000;
  localparam logic [63:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] Q_MIN = 64'h8000_0000_0000_0000;

  // Configuration register indexes.
  localparam logic [7:0] REG_POINTS_FIRST  = 8'd0;
  localparam logic [7:0] REG_POINTS_SECOND = 8'd1;
  localparam logic [7:0] REG_REFINE_FIRST  = 8'd2;
  localparam logic [7:0] REG_REFINE_SECOND = 8'd3;

  // Clamped job settings as used by the front and back ends.
  typedef struct packed {
    logic [12:0] p1;
    logic [12:0] p2;
    logic [3:0]  r1;
    logic [3:0]  r2;
  } setup_t;

  // One classified entry: update terms for one column and its position.
  typedef struct packed {
    logic [63:0] growth;
    logic [63:0] damping;
    logic [11:0] col;
    logic        last_col;
    logic        last_row;
  } qitem_t;

endpackage

[hdl/sigk_ram.sv]
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module sigk_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/sigk_front.sv]
// Front end: accepts Gram entries, tracks row and column position and
// computes the two update terms per entry. Depends on sigk_pkg.
module sigk_front import sigk_pkg::*; #(
  parameter int MAX_POINTS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  setup_t      setup,
  input  logic        clear_busy,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] gram_entry,
  output qitem_t      item,
  output logic        item_valid,
  input  logic        item_ready
);

  localparam int ColW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;

  typedef enum logic [2:0] {F_IDLE, F_SQUARE, F_SCALE, F_DIVIDE, F_PUSH} fstate_t;

  fstate_t            state;
  logic [ColW-1:0]    column_count;
  logic [ColW-1:0]    row_count;
  logic [ColW-1:0]    col;
  logic               last_col;
  logic               last_row;
  logic [31:0]        g;
  logic signed [63:0] halfd;
  logic [63:0]        sq;
  logic [55:0]        y;
  logic [55:0]        quot;
  logic [1:0]         rem;
  logic [3:0]         cnt;

  logic [4:0]         s;
  logic [5:0]         sh;
  logic signed [63:0] gx;
  logic [31:0]        mag;
  logic [63:0]        x;
  logic [5:0]         n;
  logic [11:0]        prod;
  logic [3:0]         q;
  logic [5:0]         r_next;
  logic               at_last_col;
  logic               at_last_row;

  // Scaling arithmetic for the current entry.
  always_comb begin
    s      = 5'(setup.r1) + 5'(setup.r2);
    sh     = 6'd8 + {s, 1'b0};
    gx     = {{32{gram_entry[31]}}, gram_entry};
    mag    = g[31] ? 32'(-g) : g;
    x      = sq + (64'd6 << sh);
    n      = {rem, y[55:52]};
    prod   = 12'(n) * 12'd43;
    q      = prod[10:7];
    r_next = n - {1'b0, q, 1'b0} - {2'b00, q};
    at_last_col = (13'(column_count) == setup.p2 - 13'd2);
    at_last_row = (13'(row_count) == setup.p1 - 13'd2);
  end

  assign in_ready   = (state == F_IDLE) && !clear_busy;
  assign item_valid = (state == F_PUSH);

  always_comb begin
    item.growth   = Q_ONE + halfd + {8'd0, quot};
    item.damping  = Q_ONE - {8'd0, quot};
    item.col      = 12'(col);
    item.last_col = last_col;
    item.last_row = last_row;
  end

  // Sequencer: square, scale, divide by three a nibble per cycle, hand off.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= F_IDLE;
      column_count <= '0;
      row_count    <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid && in_ready) begin
            g        <= gram_entry;
            col      <= column_count;
            last_col <= at_last_col;
            last_row <= at_last_col && at_last_row;
            halfd    <= (s <= 5'd15) ? (gx <<< (5'd15 - s)) : (gx >>> 1);
            if (at_last_col) begin
              column_count <= '0;
              row_count    <= at_last_row ? '0 : row_count + 1'b1;
            end else begin
              column_count <= column_count + 1'b1;
            end
            state <= F_SQUARE;
          end
        end
        F_SQUARE: begin
          sq    <= 64'(mag) * 64'(mag);
          state <= F_SCALE;
        end
        F_SCALE: begin
          y     <= 56'(x >> (sh + 6'd2));
          rem   <= '0;
          cnt   <= '0;
          state <= F_DIVIDE;
        end
        F_DIVIDE: begin
          quot <= {quot[51:0], q};
          rem  <= r_next[1:0];
          y    <= {y[51:0], 4'd0};
          cnt  <= cnt + 4'd1;
          if (cnt == 4'd13) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (item_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

[hdl/sigk_queue.sv]
// Two-entry queue of classified entries between front and back ends.
// Depends on sigk_pkg.
module sigk_queue import sigk_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  qitem_t push_item,
  input  logic   push_valid,
  output logic   push_ready,
  output qitem_t pop_item,
  output logic   pop_valid,
  input  logic   pop_ready
);

  qitem_t     slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = slots[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= ~wptr;
      end
      if (do_pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_item;
    end
  end

endmodule

[hdl/sigk_back.sv]
// Back end: stores update terms, sweeps the refined grid over the line store,
// emits the corner value and clears the store. Depends on sigk_pkg, sigk_ram.
module sigk_back import sigk_pkg::*; #(
  parameter int MAX_POINTS = 256,
  parameter int MAX_REFINE = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  setup_t      setup,
  input  qitem_t      item,
  input  logic        item_valid,
  output logic        item_ready,
  output logic        clear_busy,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] kernel_value,
  output logic        saturated
);

  localparam int ColW       = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
  localparam int KW         = (MAX_REFINE > 0) ? MAX_REFINE : 1;
  localparam int StoreDepth = ((MAX_POINTS - 1) << MAX_REFINE) + 1;
  localparam int AW         = $clog2(StoreDepth);

  typedef enum logic [3:0] {
    B_CLEAR, B_IDLE, B_READ, B_LOAD, B_MAC, B_ROUND, B_FETCH, B_FWAIT
  } bstate_t;

  bstate_t          state;
  logic [AW-1:0]    clr_idx;
  logic [KW-1:0]    sub;
  logic [KW-1:0]    k;
  logic [ColW-1:0]  col;
  logic             last_row;
  logic             overflow_seen;
  logic [63:0]      left;
  logic [63:0]      diag;
  logic [63:0]      up_reg;
  logic [64:0]      a_mag;
  logic [63:0]      b_mag;
  logic [63:0]      c_mag;
  logic [63:0]      d_mag;
  logic             a_neg;
  logic             c_neg;
  logic [3:0]       step;
  logic [127:0]     acc;

  logic             term_we;
  logic [63:0]      grow_rd;
  logic [63:0]      damp_rd;
  logic             store_we;
  logic [AW-1:0]    store_waddr;
  logic [63:0]      store_wdata;
  logic [AW-1:0]    store_raddr;
  logic [63:0]      store_rd;
  logic [AW-1:0]    idx;
  logic [AW-1:0]    corner;
  logic [KW:0]      kmax;
  logic [KW:0]      submax;
  logic signed [64:0] sum;
  logic [31:0]      op_x;
  logic [31:0]      op_y;
  logic [1:0]       op_sh;
  logic             op_neg;
  logic [127:0]     pp;
  logic [127:0]     rnd;
  logic             fits;
  logic [63:0]      cell_val;

  // Addressing for the current cell and the final corner. The left plus up
  // sum is formed from the store read data while it is being loaded.
  always_comb begin
    idx    = AW'((AW'(col) << setup.r2) + AW'(k) + 1'b1);
    corner = AW'(AW'(setup.p2 - 13'd1) << setup.r2);
    kmax   = ((KW + 1)'(1) << setup.r2) - 1'b1;
    submax = ((KW + 1)'(1) << setup.r1) - 1'b1;
    sum    = {left[63], left} + {store_rd[63], store_rd};
  end

  assign item_ready = (state == B_IDLE);
  assign clear_busy = (state == B_CLEAR);
  assign term_we    = item_valid && item_ready;

  sigk_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_grow (
    .clk(clk), .we(term_we), .waddr(item.col[ColW-1:0]), .wdata(item.growth),
    .raddr(col), .rdata(grow_rd)
  );

  sigk_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_damp (
    .clk(clk), .we(term_we), .waddr(item.col[ColW-1:0]), .wdata(item.damping),
    .raddr(col), .rdata(damp_rd)
  );

  // Line store port selection: clearing sweep, cell write-back, reads.
  always_comb begin
    store_we    = (state == B_CLEAR) || (state == B_ROUND);
    store_waddr = (state == B_CLEAR) ? clr_idx : idx;
    store_wdata = (state == B_CLEAR) ? Q_ONE : cell_val;
    store_raddr = (state == B_FETCH) ? corner : idx;
  end

  sigk_ram #(.WIDTH(64), .DEPTH(StoreDepth)) u_store (
    .clk(clk), .we(store_we), .waddr(store_waddr), .wdata(store_wdata),
    .raddr(store_raddr), .rdata(store_rd)
  );

  // Partial product schedule: (left+up)*grow in six steps, diag*damp in four.
  always_comb begin
    op_x   = '0;
    op_y   = '0;
    op_sh  = 2'd0;
    op_neg = a_neg;
    case (step)
      4'd0: begin op_x = a_mag[31:0];  op_y = b_mag[31:0];  op_sh = 2'd0; end
      4'd1: begin op_x = a_mag[31:0];  op_y = b_mag[63:32]; op_sh = 2'd1; end
      4'd2: begin op_x = a_mag[63:32]; op_y = b_mag[31:0];  op_sh = 2'd1; end
      4'd3: begin op_x = a_mag[63:32]; op_y = b_mag[63:32]; op_sh = 2'd2; end
      4'd4: begin op_x = {31'd0, a_mag[64]}; op_y = b_mag[31:0];  op_sh = 2'd2; end
      4'd5: begin op_x = {31'd0, a_mag[64]}; op_y = b_mag[63:32]; op_sh = 2'd3; end
      4'd6: begin
        op_x = c_mag[31:0];  op_y = d_mag[31:0];  op_sh = 2'd0; op_neg = !c_neg;
      end
      4'd7: begin
        op_x = c_mag[31:0];  op_y = d_mag[63:32]; op_sh = 2'd1; op_neg = !c_neg;
      end
      4'd8: begin
        op_x = c_mag[63:32]; op_y = d_mag[31:0];  op_sh = 2'd1; op_neg = !c_neg;
      end
      4'd9: begin
        op_x = c_mag[63:32]; op_y = d_mag[63:32]; op_sh = 2'd2; op_neg = !c_neg;
      end
      default: begin op_x = '0; op_y = '0; end
    endcase
    pp = 128'(64'(op_x) * 64'(op_y)) << {op_sh, 5'd0};
  end

  // Round to Q.40 with ties upward, then saturate to 64 bits.
  always_comb begin
    rnd      = acc + (128'd1 << 39);
    fits     = (rnd[127:103] == '0) || (rnd[127:103] == '1);
    cell_val = fits ? rnd[103:40] : (rnd[127] ? Q_MIN : Q_MAX);
  end

  // Sweep sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= B_CLEAR;
      clr_idx       <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == AW'(StoreDepth - 1)) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (item_valid && item.last_col) begin
            sub      <= '0;
            k        <= '0;
            col      <= '0;
            left     <= Q_ONE;
            diag     <= Q_ONE;
            last_row <= item.last_row;
            state    <= B_READ;
          end
        end
        B_READ: begin
          state <= B_LOAD;
        end
        B_LOAD: begin
          up_reg <= store_rd;
          a_mag  <= sum[64] ? 65'(-sum) : 65'(sum);
          a_neg  <= sum[64] ^ grow_rd[63];
          b_mag  <= grow_rd[63] ? 64'(-grow_rd) : grow_rd;
          c_mag  <= diag[63] ? 64'(-diag) : diag;
          d_mag  <= damp_rd[63] ? 64'(-damp_rd) : damp_rd;
          c_neg  <= diag[63] ^ damp_rd[63];
          acc    <= '0;
          step   <= '0;
          state  <= B_MAC;
        end
        B_MAC: begin
          acc  <= op_neg ? (acc - pp) : (acc + pp);
          step <= step + 4'd1;
          if (step == 4'd9) begin
            state <= B_ROUND;
          end
        end
        B_ROUND: begin
          if (!fits) begin
            overflow_seen <= 1'b1;
          end
          diag  <= up_reg;
          left  <= cell_val;
          state <= B_READ;
          if ((KW + 1)'(k) == kmax) begin
            k <= '0;
            if (13'(col) == setup.p2 - 13'd2) begin
              col <= '0;
              if ((KW + 1)'(sub) == submax) begin
                state <= last_row ? B_FETCH : B_IDLE;
              end else begin
                sub  <= sub + 1'b1;
                left <= Q_ONE;
                diag <= Q_ONE;
              end
            end else begin
              col <= col + 1'b1;
            end
          end else begin
            k <= k + 1'b1;
          end
        end
        B_FETCH: begin
          if (!out_valid) begin
            state <= B_FWAIT;
          end
        end
        B_FWAIT: begin
          kernel_value  <= store_rd;
          saturated     <= overflow_seen;
          out_valid     <= 1'b1;
          overflow_seen <= 1'b0;
          clr_idx       <= '0;
          state         <= B_CLEAR;
        end
        default: state <= B_CLEAR;
      endcase
    end
  end

  // The clearing sweep never overlaps intake of new entries.
  a_clear_no_pop: assert property (@(posedge clk) disable iff (rst)
    (state == B_CLEAR) |-> !item_ready)
    else $error("entry popped during store clear");

  // Cell write-back never touches the fixed boundary entry.
  a_no_boundary_write: assert property (@(posedge clk) disable iff (rst)
    (state == B_ROUND) |-> (idx != '0))
    else $error("grid write hit boundary entry");

  // A result appears only out of the corner fetch.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == B_FWAIT))
    else $error("result raised outside corner fetch");

endmodule

[hdl/signature_kernel_pde_solver.sv]
// The front end squares, scales and divides each entry; a row sweep then visits
// 2^(refine_first+refine_second)*(points_second-1) grid cells.
// Throughput is set by the shared 32x32 multiplier in the back end (ten
// partial products per cell); the front end stays ahead through a 2-entry queue.
// Reset is synchronous; afterwards and after every result the line store's
// ((MAX_POINTS-1)<<MAX_REFINE)+1 entries are cleared with input held off.
module signature_kernel_pde_solver import sigk_pkg::*; #(
  parameter int MAX_POINTS = 256,
  parameter int MAX_REFINE = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] gram_entry,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] kernel_value,
  output logic        saturated
);

  logic [8:0] points_first;
  logic [8:0] points_second;
  logic [2:0] refine_first;
  logic [2:0] refine_second;
  setup_t     setup;
  qitem_t     f_item;
  logic       f_valid;
  logic       f_ready;
  qitem_t     b_item;
  logic       b_valid;
  logic       b_ready;
  logic       clear_busy;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      points_first  <= 9'd2;
      points_second <= 9'd2;
      refine_first  <= 3'd0;
      refine_second <= 3'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_POINTS_FIRST:  points_first  <= cfg_data[8:0];
        REG_POINTS_SECOND: points_second <= cfg_data[8:0];
        REG_REFINE_FIRST:  refine_first  <= cfg_data[2:0];
        REG_REFINE_SECOND: refine_second <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Clamp settings to the supported ranges.
  always_comb begin
    setup.p1 = 13'(points_first);
    if (setup.p1 < 13'd2) setup.p1 = 13'd2;
    if (setup.p1 > 13'(MAX_POINTS)) setup.p1 = 13'(MAX_POINTS);
    setup.p2 = 13'(points_second);
    if (setup.p2 < 13'd2) setup.p2 = 13'd2;
    if (setup.p2 > 13'(MAX_POINTS)) setup.p2 = 13'(MAX_POINTS);
    setup.r1 = (4'(refine_first) > 4'(MAX_REFINE)) ? 4'(MAX_REFINE) : 4'(refine_first);
    setup.r2 = (4'(refine_second) > 4'(MAX_REFINE)) ? 4'(MAX_REFINE) : 4'(refine_second);
  end

  sigk_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk(clk), .rst(rst), .setup(setup), .clear_busy(clear_busy),
    .in_valid(in_valid), .in_ready(in_ready), .gram_entry(gram_entry),
    .item(f_item), .item_valid(f_valid), .item_ready(f_ready)
  );

  sigk_queue u_queue (
    .clk(clk), .rst(rst),
    .push_item(f_item), .push_valid(f_valid), .push_ready(f_ready),
    .pop_item(b_item), .pop_valid(b_valid), .pop_ready(b_ready)
  );

  sigk_back #(.MAX_POINTS(MAX_POINTS), .MAX_REFINE(MAX_REFINE)) u_back (
    .clk(clk), .rst(rst), .setup(setup),
    .item(b_item), .item_valid(b_valid), .item_ready(b_ready),
    .clear_busy(clear_busy),
    .out_valid(out_valid), .out_ready(out_ready),
    .kernel_value(kernel_value), .saturated(saturated)
  );

endmodule
